@@ rtl/tdm_pkg.sv @@
// Shared types, register indexes, derating codes and threshold helpers.
`timescale 1ns / 1ps
package tdm_pkg;

   typedef logic [2:0]          csr_index_type;
   typedef logic [6:0]          pct_type;
   typedef logic [3:0]          alive_type;
   typedef logic signed [15:0]  deci_type;

   localparam csr_index_type CSR_TEMP_MIN     = 3'd0;
   localparam csr_index_type CSR_TEMP_MAX     = 3'd1;
   localparam csr_index_type CSR_DERATE_START = 3'd2;
   localparam csr_index_type CSR_DERATE_HALF  = 3'd3;
   localparam csr_index_type CSR_SHUTDOWN     = 3'd4;
   localparam csr_index_type CSR_HYSTERESIS   = 3'd5;

   localparam pct_type PCT_FULL  = 7'd100;
   localparam pct_type PCT_THREE = 7'd75;
   localparam pct_type PCT_HALF  = 7'd50;
   localparam pct_type PCT_NONE  = 7'd0;

   localparam alive_type ALIVE_MAX = 4'd15;

   localparam deci_type TEMP_MIN_RESET = -16'sd300;
   localparam deci_type TEMP_MAX_RESET = 16'sd1500;
   localparam logic [7:0] DERATE_START_RESET = 8'd60;
   localparam logic [7:0] DERATE_HALF_RESET  = 8'd80;
   localparam logic [7:0] SHUTDOWN_RESET     = 8'd100;
   localparam logic [7:0] HYSTERESIS_RESET   = 8'd10;

   typedef struct packed {
      deci_type   temp_min;
      deci_type   temp_max;
      logic [7:0] derate_start;
      logic [7:0] derate_half;
      logic [7:0] shutdown;
      logic [7:0] hysteresis;
   } cfg_type;

   typedef struct packed {
      deci_type  stored_temp;
      pct_type   derate;
      logic      fault;
      alive_type alive;
   } state_type;

   typedef struct packed {
      deci_type  temp_out;
      pct_type   derate_pct;
      logic      sensor_fault;
      alive_type alive_count;
      logic      frame_sent;
      logic      overtemp_event;
   } result_type;

   // True when the sample, truncated toward zero to whole degrees, is below x.
   // Works in tenths: for x > 0 the limit is 10x, otherwise 10x - 9.
   function automatic logic below_deg(deci_type t, logic signed [9:0] x);
      logic signed [16:0] xe;
      logic signed [16:0] ten;
      logic signed [16:0] lim;
      logic signed [16:0] te;
      xe  = $signed({{7{x[9]}}, x});
      ten = (xe <<< 3) + (xe <<< 1);
      lim = (x > 10'sd0) ? ten : ten - 17'sd9;
      te  = $signed({t[15], t});
      return te < lim;
   endfunction

   function automatic logic signed [9:0] deg_of(logic [7:0] thr);
      return $signed({2'b00, thr});
   endfunction

   function automatic logic signed [9:0] recover_limit(logic [7:0] thr, logic [7:0] hyst);
      return $signed({2'b00, thr}) - $signed({2'b00, hyst});
   endfunction

endpackage

@@ rtl/tdm_update.sv @@
// Per-sample plausibility check, derating step with hysteresis and state update.
`timescale 1ns / 1ps
module tdm_update (
   input  tdm_pkg::cfg_type    cfg,
   input  tdm_pkg::state_type  cur,
   input  tdm_pkg::deci_type   sample,
   output tdm_pkg::state_type  nxt,
   output tdm_pkg::result_type res
);
   import tdm_pkg::*;

   logic    out_of_range;
   pct_type raw_pct;
   pct_type step_pct;

   assign out_of_range = (sample < cfg.temp_min) || (sample > cfg.temp_max);

   // First threshold not reached decides.
   always_comb begin
      if (below_deg(sample, deg_of(cfg.derate_start))) begin
         raw_pct = PCT_FULL;
      end else if (below_deg(sample, deg_of(cfg.derate_half))) begin
         raw_pct = PCT_THREE;
      end else if (below_deg(sample, deg_of(cfg.shutdown))) begin
         raw_pct = PCT_HALF;
      end else begin
         raw_pct = PCT_NONE;
      end
   end

   // Worsen at once, recover one step when cold enough.
   always_comb begin
      step_pct = cur.derate;
      if (raw_pct <= cur.derate) begin
         step_pct = raw_pct;
      end else begin
         case (cur.derate)
            PCT_NONE: begin
               if (below_deg(sample, recover_limit(cfg.shutdown, cfg.hysteresis)))
                  step_pct = PCT_HALF;
            end
            PCT_HALF: begin
               if (below_deg(sample, recover_limit(cfg.derate_half, cfg.hysteresis)))
                  step_pct = PCT_THREE;
            end
            PCT_THREE: begin
               if (below_deg(sample, recover_limit(cfg.derate_start, cfg.hysteresis)))
                  step_pct = PCT_FULL;
            end
            default: step_pct = cur.derate;
         endcase
      end
   end

   always_comb begin
      nxt = cur;
      res.alive_count = cur.alive;
      if (out_of_range) begin
         nxt.fault          = 1'b1;
         res.temp_out       = cur.stored_temp;
         res.derate_pct     = cur.derate;
         res.sensor_fault   = 1'b1;
         res.frame_sent     = 1'b0;
         res.overtemp_event = 1'b1;
      end else begin
         nxt.stored_temp    = sample;
         nxt.derate         = step_pct;
         nxt.alive          = (cur.alive >= ALIVE_MAX) ? 4'd0 : cur.alive + 4'd1;
         res.temp_out       = sample;
         res.derate_pct     = step_pct;
         res.sensor_fault   = cur.fault;
         res.frame_sent     = 1'b1;
         res.overtemp_event = (step_pct == PCT_NONE);
      end
   end

endmodule

@@ rtl/thermal_derating_monitor.sv @@
// Top level: input register, state update, result register and control registers.
`timescale 1ns / 1ps
// Takes one temperature sample per cycle while req_stall is low and returns one
// status item per sample: the sample is held in an input register, and the
// plausibility check, derating step and state update run between that register
// and the result register. The state update commits as the item moves into the
// result register, so consecutive samples see each other's effect with no gap.
// req_stall rises only while the input register is full and the result register
// holds an item that the consumer is stalling. Control registers are written
// through the csr_ port, which is always ready; write them only while no item is
// in flight. Indexes beyond the register list are ignored.
module thermal_derating_monitor (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tdm_pkg::deci_type        req_temp_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tdm_pkg::deci_type        rsp_temp_out,
   output tdm_pkg::pct_type         rsp_derate_pct,
   output logic                     rsp_sensor_fault,
   output tdm_pkg::alive_type       rsp_alive_count,
   output logic                     rsp_frame_sent,
   output logic                     rsp_overtemp_event,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  tdm_pkg::csr_index_type   csr_index,
   input  logic [15:0]              csr_wdata
);
   import tdm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   logic       in_valid_ff, in_valid_in;
   deci_type   in_temp_ff, in_temp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   state_type  state_nxt;
   result_type res_nxt;
   logic       out_free;
   logic       advance;
   logic       req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   tdm_update u_update (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .sample (in_temp_ff),
      .nxt    (state_nxt),
      .res    (res_nxt)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEMP_MIN:     cfg_in.temp_min     = $signed(csr_wdata);
            CSR_TEMP_MAX:     cfg_in.temp_max     = $signed(csr_wdata);
            CSR_DERATE_START: cfg_in.derate_start = csr_wdata[7:0];
            CSR_DERATE_HALF:  cfg_in.derate_half  = csr_wdata[7:0];
            CSR_SHUTDOWN:     cfg_in.shutdown     = csr_wdata[7:0];
            CSR_HYSTERESIS:   cfg_in.hysteresis   = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_temp_in   = in_temp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      state_in     = state_ff;
      if (advance) begin
         state_in     = state_nxt;
         rsp_in       = res_nxt;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      // Input register drains on advance and refills on accept.
      if (advance) in_valid_in = 1'b0;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_temp_in  = req_temp_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_min     <= TEMP_MIN_RESET;
         cfg_ff.temp_max     <= TEMP_MAX_RESET;
         cfg_ff.derate_start <= DERATE_START_RESET;
         cfg_ff.derate_half  <= DERATE_HALF_RESET;
         cfg_ff.shutdown     <= SHUTDOWN_RESET;
         cfg_ff.hysteresis   <= HYSTERESIS_RESET;
         state_ff.stored_temp <= '0;
         state_ff.derate      <= PCT_FULL;
         state_ff.fault       <= 1'b0;
         state_ff.alive       <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_temp_ff <= in_temp_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_temp_out       = rsp_ff.temp_out;
   assign rsp_derate_pct     = rsp_ff.derate_pct;
   assign rsp_sensor_fault   = rsp_ff.sensor_fault;
   assign rsp_alive_count    = rsp_ff.alive_count;
   assign rsp_frame_sent     = rsp_ff.frame_sent;
   assign rsp_overtemp_event = rsp_ff.overtemp_event;

endmodule

@@ rtl/tdm_checker.sv @@
// Port-level assertions for the thermal derating monitor, bound to the top level.
`timescale 1ns / 1ps
module tdm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input tdm_pkg::deci_type  rsp_temp_out,
   input tdm_pkg::pct_type   rsp_derate_pct,
   input logic               rsp_sensor_fault,
   input tdm_pkg::alive_type rsp_alive_count,
   input logic               rsp_frame_sent,
   input logic               rsp_overtemp_event
);
   import tdm_pkg::*;

   // Fault flag is sticky across items.
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sensor_fault |=> !rsp_valid || rsp_sensor_fault)
      else $error("sensor fault flag cleared after being set");

   // A dropped frame only comes from a rejected sample.
   a_drop_is_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_sent |-> rsp_overtemp_event && rsp_sensor_fault)
      else $error("frame dropped without fault and event");

   // On a sent frame the event mirrors zero derating.
   a_event_on_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_sent |-> rsp_overtemp_event == (rsp_derate_pct == PCT_NONE))
      else $error("overtemp event disagrees with derating");

   a_pct_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_derate_pct == PCT_FULL || rsp_derate_pct == PCT_THREE ||
                    rsp_derate_pct == PCT_HALF || rsp_derate_pct == PCT_NONE)
      else $error("derating outside its four steps");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temp_out) &&
                                 $stable(rsp_alive_count) && $stable(rsp_derate_pct))
      else $error("stalled item changed");

endmodule

bind thermal_derating_monitor tdm_checker u_tdm_checker (.*);
